// File: src/rpa_pkg.sv
// ---------------------------------------------------------------------------
// rpa_pkg
// Types, field widths and codes shared by the page allocator files.
// ---------------------------------------------------------------------------
package rpa_pkg;

   localparam int OP_W      = 3;
   localparam int PAGE_W    = 15;
   localparam int STATUS_W  = 3;
   localparam int CNT_OUT_W = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
   localparam logic [OP_W-1:0] OP_INCREF = 3'd3;
   localparam logic [OP_W-1:0] OP_GETREF = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_FILL,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAGE_W-1:0]    result_page;
      logic [CNT_OUT_W-1:0] ref_count;
      logic                 page_released;
   } rsp_type;

endpackage

// File: src/rpa_if.sv
// ---------------------------------------------------------------------------
// rpa_if
// Valid/ready channels of the page allocator: request, response and csr.
// ---------------------------------------------------------------------------
interface rpa_req_if import rpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [PAGE_W-1:0] page;

   modport source (output valid, output operation, output page, input ready);
   modport sink   (input valid, input operation, input page, output ready);
endinterface

interface rpa_rsp_if import rpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PAGE_W-1:0]    result_page;
   logic [CNT_OUT_W-1:0] ref_count;
   logic                 page_released;

   modport source (output valid, output status, output result_page, output ref_count,
                   output page_released, input ready);
   modport sink   (input valid, input status, input result_page, input ref_count,
                   input page_released, output ready);
endinterface

interface rpa_csr_if import rpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/refcounted_page_allocator_top.sv
// ---------------------------------------------------------------------------
// refcounted_page_allocator_top
// Alloc, free, incref and getref move from the idle to the exec state,
//   where the response register is loaded once free; a new request is
//   accepted only back in the idle state, after the count memory write.
// Init sweeps the count and stack memories over every page index.
// After reset a clearing pass over every index zeroes the counts while
//   req_chan.ready stays low; csr writes are taken throughout.
// ---------------------------------------------------------------------------
module refcounted_page_allocator_top import rpa_pkg::*; #(
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 8
) (
   input logic        clock,
   input logic        reset,
   rpa_req_if.sink    req_chan,
   rpa_rsp_if.source  rsp_chan,
   rpa_csr_if.sink    csr_chan
);

   logic [PAGE_W-1:0] first_page_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_ready;
   logic              rsp_free;
   logic              rsp_load;
   rsp_type           rsp_data;
   req_type           req_data;

   assign csr_chan.ready = 1'b1;
   assign req_data       = req_type'{operation: req_chan.operation, page: req_chan.page};
   assign req_chan.ready = req_ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   rpa_engine #(
      .NUM_PAGES  (NUM_PAGES),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .first_page (first_page_ff),
      .req_valid  (req_chan.valid),
      .req_data   (req_data),
      .req_ready  (req_ready),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .rsp_data   (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else if (csr_chan.valid) begin
         first_page_ff <= csr_chan.data;
      end
   end

   // response register, parts the engine from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= rsp_data;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.result_page   = rsp_data_ff.result_page;
   assign rsp_chan.ref_count     = rsp_data_ff.ref_count;
   assign rsp_chan.page_released = rsp_data_ff.page_released;

   // clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second request accepted while one is in flight");

   a_release_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.page_released |->
         rsp_chan.status == ST_OK && rsp_chan.ref_count == '0 && rsp_chan.result_page == '0)
      else $error("released page with inconsistent response");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_page != '0 |->
         rsp_chan.status == ST_OK && rsp_chan.ref_count == CNT_OUT_W'(1))
      else $error("allocated page without count of one");

endmodule

// File: src/rpa_engine.sv
// ---------------------------------------------------------------------------
// rpa_engine
// Count memory and free stack memory with the read-modify-write sequencer,
// the init fill sweep and the post-reset clearing sweep.
// ---------------------------------------------------------------------------
module rpa_engine import rpa_pkg::*; #(
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [PAGE_W-1:0] first_page,
   input  logic              req_valid,
   input  req_type           req_data,
   output logic              req_ready,
   input  logic              rsp_free,
   output logic              rsp_load,
   output rsp_type           rsp_data
);

   localparam int AW = $clog2(NUM_PAGES);
   localparam int DW = $clog2(NUM_PAGES + 1);
   localparam int SW = ((AW > PAGE_W) ? AW : PAGE_W) + 1;
   localparam logic [AW-1:0]         LAST_IDX = AW'(NUM_PAGES - 1);
   localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

   logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
   logic [PAGE_W-1:0]     stack_mem [NUM_PAGES];

   state_type             state_ff, state_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic [OP_W-1:0]       op_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [PAGE_W-1:0]     stack_rd_ff;

   logic                  accept;
   logic                  last_idx;
   logic                  do_exec;
   logic [AW-1:0]         rd_page_addr;
   logic [AW-1:0]         rd_stack_addr;
   logic [SW-1:0]         fill_sum;
   logic                  fill_push;
   logic                  page_ok;
   logic                  popped_ok;
   logic                  stack_room;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] cnt_dec;

   logic                  cnt_we;
   logic [AW-1:0]         cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  stk_we;
   logic [AW-1:0]         stk_waddr;
   logic [PAGE_W-1:0]     stk_wdata;

   assign req_ready     = (state_ff == S_IDLE);
   assign accept        = req_valid && req_ready;
   assign last_idx      = (idx_ff == LAST_IDX);
   assign do_exec       = (state_ff == S_EXEC) && rsp_free;
   assign rd_page_addr  = AW'(req_data.page);
   assign rd_stack_addr = AW'(depth_ff - 1'b1);
   assign fill_sum      = SW'(first_page) + SW'(idx_ff);
   assign fill_push     = (fill_sum < SW'(NUM_PAGES));
   assign page_ok       = (32'(page_ff) < 32'(NUM_PAGES));
   assign popped_ok     = (32'(stack_rd_ff) < 32'(NUM_PAGES));
   assign stack_room    = (32'(depth_ff) < 32'(NUM_PAGES));
   assign cnt_inc       = count_rd_ff + CNT_ONE;
   assign cnt_dec       = count_rd_ff - CNT_ONE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (last_idx) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = (req_data.operation == OP_INIT) ? S_FILL : S_EXEC;
         end
         S_FILL: begin
            if (last_idx) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory writes, counters and response
   always_comb begin
      idx_in    = idx_ff;
      depth_in  = depth_ff;
      cnt_we    = 1'b0;
      cnt_waddr = AW'(page_ff);
      cnt_wdata = '0;
      stk_we    = 1'b0;
      stk_waddr = AW'(depth_ff);
      stk_wdata = page_ff;
      rsp_load  = do_exec;
      rsp_data  = '0;

      case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff;
            idx_in    = last_idx ? '0 : idx_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept && req_data.operation == OP_INIT) begin
               depth_in = '0;
               idx_in   = '0;
            end
         end
         S_FILL: begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff;
            idx_in    = last_idx ? '0 : idx_ff + 1'b1;
            if (fill_push) begin
               stk_we    = 1'b1;
               stk_waddr = idx_ff;
               stk_wdata = PAGE_W'(fill_sum);
               depth_in  = depth_ff + 1'b1;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_INIT: begin
               end
               OP_ALLOC: begin
                  if (depth_ff == '0) begin
                     rsp_data.status = ST_OOM;
                  end else begin
                     rsp_data.result_page = stack_rd_ff;
                     rsp_data.ref_count   = CNT_OUT_W'(1);
                     depth_in             = do_exec ? depth_ff - 1'b1 : depth_ff;
                     cnt_waddr            = AW'(stack_rd_ff);
                     cnt_wdata            = CNT_ONE;
                     cnt_we               = do_exec && popped_ok;
                  end
               end
               OP_FREE: begin
                  if (!page_ok) begin
                     rsp_data.status = ST_RANGE;
                  end else if (page_ff < first_page) begin
                     rsp_data.status    = ST_RANGE;
                     rsp_data.ref_count = CNT_OUT_W'(count_rd_ff);
                  end else if (count_rd_ff == '0) begin
                     rsp_data.status = ST_DBL_FREE;
                  end else begin
                     cnt_we    = do_exec;
                     cnt_wdata = cnt_dec;
                     // back onto the stack once the last reference is gone, if the stack has room
                     if (cnt_dec == '0 && stack_room) begin
                        stk_we                 = do_exec;
                        depth_in               = do_exec ? depth_ff + 1'b1 : depth_ff;
                        rsp_data.page_released = 1'b1;
                     end else begin
                        rsp_data.ref_count = CNT_OUT_W'(cnt_dec);
                     end
                  end
               end
               OP_INCREF: begin
                  if (!page_ok) begin
                     rsp_data.status = ST_RANGE;
                  end else if (count_rd_ff == '1) begin
                     rsp_data.status    = ST_SATURATED;
                     rsp_data.ref_count = CNT_OUT_W'(count_rd_ff);
                  end else begin
                     cnt_we             = do_exec;
                     cnt_wdata          = cnt_inc;
                     rsp_data.ref_count = CNT_OUT_W'(cnt_inc);
                  end
               end
               OP_GETREF: begin
                  if (!page_ok) begin
                     rsp_data.status = ST_RANGE;
                  end else begin
                     rsp_data.ref_count = CNT_OUT_W'(count_rd_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_data.operation;
         page_ff <= req_data.page;
      end
   end

   // reads issue with the accepted request; the registered data is used in the exec state
   always_ff @(posedge clock) begin
      if (accept) begin
         count_rd_ff <= count_mem[rd_page_addr];
         stack_rd_ff <= stack_mem[rd_stack_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
   end

endmodule
